### src/set_assoc_search_table_unit_defines.svh
// Assertion macros shared by the set-associative search table RTL.
`ifndef SET_ASSOC_SEARCH_TABLE_UNIT_DEFINES_SVH
`define SET_ASSOC_SEARCH_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SAST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SAST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sast_pkg.sv
// Shared constants, types and helper functions of the search table.
package sast_pkg;

  localparam int SET_INDEX_BITS = 10;
  localparam int WAYS           = 4;
  localparam int NUM_SETS       = 1 << SET_INDEX_BITS;
  localparam int ADDR_BITS      = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1;
  localparam int WAY_BITS       = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [7:0] GEN_MASK  = 8'hFC;
  localparam logic [7:0] AGE_MASK  = 8'h3F;
  localparam logic [7:0] GEN_STEP  = 8'd4;
  localparam logic signed [7:0] DEPTH_MIN = -8'sd127;
  localparam logic signed [7:0] DEPTH_MAX = 8'sd127;
  localparam logic [14:0] MATE_THRESHOLD_RESET = 15'd32000;

  typedef enum logic [1:0] {
    OP_PROBE    = 2'd0,
    OP_STORE    = 2'd1,
    OP_NEW_GEN  = 2'd2
  } op_t;

  localparam logic [1:0] BND_NONE  = 2'd0;
  localparam logic [1:0] BND_UPPER = 2'd1;

  typedef logic [ADDR_BITS-1:0] set_addr_t;
  typedef logic [WAY_BITS-1:0]  way_idx_t;

  // One stored way; generation sits in gen_bound[7:2], bound in [1:0].
  typedef struct packed {
    logic [63:0] key;
    logic [15:0] score;
    logic [15:0] eval;
    logic [15:0] move;
    logic [7:0]  depth;
    logic [7:0]  gen_bound;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  // Lookup and replacement decision for one set.
  typedef struct packed {
    logic     hit;
    way_idx_t hit_way;
    way_idx_t pick_way;
  } sel_t;

  // Set index from the low key bits.
  function automatic set_addr_t set_of(input logic [63:0] key);
    logic [63:0] masked;
    masked = key & 64'(NUM_SETS - 1);
    return masked[ADDR_BITS-1:0];
  endfunction

  // Mate scores move away from zero by ply on store, back toward it on read.
  function automatic logic [15:0] mate_adjust(input logic signed [15:0] s,
                                              input logic [7:0] ply,
                                              input logic [14:0] thr,
                                              input logic to_store);
    logic signed [16:0] s17;
    logic signed [16:0] t17;
    logic signed [16:0] p17;
    logic signed [16:0] r;
    s17 = 17'(s);
    t17 = signed'({2'b00, thr});
    p17 = signed'({9'd0, ply});
    if (s17 >= t17) begin
      r = to_store ? s17 + p17 : s17 - p17;
    end else if (s17 <= -t17) begin
      r = to_store ? s17 - p17 : s17 + p17;
    end else begin
      r = s17;
    end
    return r[15:0];
  endfunction

endpackage

### src/sast_row_ram.sv
// Set memory: one row holds every way of a set, registered read.
module sast_row_ram (
  input  logic                clk,
  input  logic                we,
  input  sast_pkg::set_addr_t waddr,
  input  sast_pkg::row_t      wdata,
  input  logic                re,
  input  sast_pkg::set_addr_t raddr,
  output sast_pkg::row_t      rdata
);
  import sast_pkg::*;

  row_t mem [NUM_SETS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/sast_way_sel.sv
// Way lookup and replacement choice over the ways of one set.
module sast_way_sel (
  input  sast_pkg::row_t row,
  input  logic [63:0]    key,
  input  logic [7:0]     cur_gen,
  output sast_pkg::sel_t sel
);
  import sast_pkg::*;

  logic              found;
  logic              hit_found;
  logic signed [9:0] best;
  logic signed [9:0] prio;
  logic [7:0]        age;

  // Probe hit is the first valid way with the same key. The store target is
  // the first empty or same-key way, else the lowest depth minus twice age.
  always_comb begin
    sel       = '0;
    found     = 1'b0;
    hit_found = 1'b0;
    best      = 10'sh1FF;
    prio      = '0;
    age       = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit_found && row[i].key == key && row[i].gen_bound[1:0] != BND_NONE) begin
        hit_found   = 1'b1;
        sel.hit     = 1'b1;
        sel.hit_way = WAY_BITS'(i);
      end
      if (!found) begin
        if (row[i].gen_bound[1:0] == BND_NONE || row[i].key == key) begin
          found        = 1'b1;
          sel.pick_way = WAY_BITS'(i);
        end else begin
          age  = (cur_gen - (row[i].gen_bound & GEN_MASK)) & AGE_MASK;
          prio = 10'(signed'(row[i].depth)) - signed'({1'b0, age[6:0], 2'b00} >> 1);
          if (prio < best) begin
            best         = prio;
            sel.pick_way = WAY_BITS'(i);
          end
        end
      end
    end
  end

endmodule

### src/set_assoc_search_table_unit.sv
// Four-way set-associative search result table, top level.
// A result is registered as the evaluation state finishes; a stalled earlier result holds it.
// A new item is taken only once the last has finished, set by the read-modify-write of one
// set row through the single set memory (read on acceptance, decide and write back on finish).
// Reset: clears control state, then sweeps all NUM_SETS (1024) set rows, zeroing the memory;
// no item is accepted during that sweep, configuration writes are taken throughout.
module set_assoc_search_table_unit (
  input  logic               clk,
  input  logic               rst,
  // Configuration write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_data,
  // Input channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [63:0]        key,
  input  logic [7:0]         ply,
  input  logic signed [15:0] score_in,
  input  logic signed [15:0] eval_in,
  input  logic [15:0]        move_word_in,
  input  logic signed [7:0]  depth_in,
  input  logic [1:0]         bound_in,
  // Result channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic signed [15:0] score_out,
  output logic signed [15:0] eval_out,
  output logic [15:0]        move_word_out,
  output logic signed [7:0]  depth_out,
  output logic [1:0]         bound_out
);
  import sast_pkg::*;

  `include "set_assoc_search_table_unit_defines.svh"

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_t;

  localparam set_addr_t LAST_SET = ADDR_BITS'(NUM_SETS - 1);

  state_t    state;
  set_addr_t clr_addr;
  logic [14:0] mate_threshold;
  logic [7:0]  cur_gen;

  // Accepted item.
  logic [1:0]         item_op;
  logic [63:0]        item_key;
  logic [7:0]         item_ply;
  logic signed [15:0] item_score;
  logic [15:0]        item_eval;
  logic [15:0]        item_move;
  logic signed [7:0]  item_depth;
  logic [1:0]         item_bound;

  // Memory ports.
  logic      ram_we;
  set_addr_t ram_waddr;
  row_t      ram_wdata;
  logic      ram_re;
  row_t      ram_rdata;

  sel_t              sel;
  entry_t            hit_entry;
  entry_t            pick_entry;
  entry_t            new_entry;
  row_t              new_row;
  logic              accept;
  logic              finish;
  logic              skip_store;
  logic signed [9:0] old_depth;
  logic signed [9:0] lim_depth;
  logic signed [7:0] clamp_depth;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign finish    = (state == ST_EVAL) && (!out_valid || out_ready);

  sast_row_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (set_of(key)),
    .rdata (ram_rdata)
  );

  sast_way_sel u_sel (
    .row     (ram_rdata),
    .key     (item_key),
    .cur_gen (cur_gen),
    .sel     (sel)
  );

  // Store path: guard against a shallow upper bound, clamp depth, build the row.
  always_comb begin
    hit_entry   = ram_rdata[sel.hit_way];
    pick_entry  = ram_rdata[sel.pick_way];
    old_depth   = 10'(signed'(pick_entry.depth));
    lim_depth   = 10'(item_depth) + 10'sd2;
    skip_store  = (item_bound == BND_UPPER) && (pick_entry.key == item_key) &&
                  (old_depth > lim_depth) &&
                  ((pick_entry.gen_bound & GEN_MASK) == cur_gen);
    if (item_depth < DEPTH_MIN) begin
      clamp_depth = DEPTH_MIN;
    end else if (item_depth > DEPTH_MAX) begin
      clamp_depth = DEPTH_MAX;
    end else begin
      clamp_depth = item_depth;
    end
    new_entry.key       = item_key;
    new_entry.score     = mate_adjust(item_score, item_ply, mate_threshold, 1'b1);
    new_entry.eval      = item_eval;
    new_entry.move      = item_move;
    new_entry.depth     = clamp_depth;
    new_entry.gen_bound = cur_gen | {6'd0, item_bound};
    new_row             = ram_rdata;
    new_row[sel.pick_way] = new_entry;
  end

  // Memory control: read of the item's set on acceptance; the clearing sweep, else write-back of a store.
  always_comb begin
    ram_re = accept;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = finish && (item_op == OP_STORE) && !skip_store;
      ram_waddr = set_of(item_key);
      ram_wdata = new_row;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mate_threshold <= MATE_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mate_threshold <= cfg_data;
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_op    <= op;
      item_key   <= key;
      item_ply   <= ply;
      item_score <= score_in;
      item_eval  <= eval_in;
      item_move  <= move_word_in;
      item_depth <= depth_in;
      item_bound <= bound_in;
    end
  end

  // Sequencer, generation counter and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      cur_gen   <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_SET) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (finish) begin
            state <= ST_IDLE;
            if (item_op == OP_PROBE && sel.hit) begin
              hit           <= 1'b1;
              score_out     <= mate_adjust(hit_entry.score, item_ply, mate_threshold,
                                           1'b0);
              eval_out      <= hit_entry.eval;
              move_word_out <= hit_entry.move;
              depth_out     <= hit_entry.depth;
              bound_out     <= hit_entry.gen_bound[1:0];
            end else begin
              hit           <= 1'b0;
              score_out     <= '0;
              eval_out      <= '0;
              move_word_out <= '0;
              depth_out     <= '0;
              bound_out     <= '0;
            end
            if (item_op == OP_NEW_GEN) begin
              cur_gen <= (cur_gen + GEN_STEP) & GEN_MASK;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // The result is raised as an evaluation finishes and dropped by its beat.
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // An accepted item is always followed by its evaluation cycle.
  `SAST_ASSERT_NEXT(a_accept_to_eval, accept, state == ST_EVAL, "accept not followed by eval")

  // The set memory is written only by the sweep or by a finishing store.
  `SAST_ASSERT_NOW(a_write_source, ram_we,
    state == ST_CLEAR || (finish && item_op == OP_STORE), "unexpected set write")

  // A new result appears only as an evaluation finishes.
  `SAST_ASSERT_NOW(a_result_origin, $rose(out_valid), $past(state == ST_EVAL),
    "result without evaluation")

endmodule

### tb/sv/search_table_checker.sv
// Reply predictor and checker for the set-associative search table.
module search_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  op,
  input  logic [63:0] key,
  input  logic [7:0]  ply,
  input  logic [15:0] score_in,
  input  logic [15:0] eval_in,
  input  logic [15:0] move_word_in,
  input  logic [7:0]  depth_in,
  input  logic [1:0]  bound_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        hit,
  input  logic [15:0] score_out,
  input  logic [15:0] eval_out,
  input  logic [15:0] move_word_out,
  input  logic [7:0]  depth_out,
  input  logic [1:0]  bound_out,
  output int          mismatch_count,
  output int          replies_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import sast_pkg::*;

  localparam int ENTRIES = NUM_SETS * WAYS;

  typedef struct packed {
    logic        hit;
    logic [15:0] score;
    logic [15:0] eval;
    logic [15:0] move;
    logic [7:0]  depth;
    logic [1:0]  bound;
  } table_reply_t;

  // Shadow copy of the table, the search generation and the threshold register.
  logic [63:0] table_key       [ENTRIES];
  logic [15:0] table_score     [ENTRIES];
  logic [15:0] table_eval      [ENTRIES];
  logic [15:0] table_move      [ENTRIES];
  logic [7:0]  table_depth     [ENTRIES];
  logic [7:0]  table_gen_bound [ENTRIES];
  logic [7:0]  search_gen;
  logic [14:0] mate_thr;

  table_reply_t expected_replies[$];

  // Mate scores move away from zero by ply when stored (dir 1) and back when read (dir -1).
  function automatic logic [15:0] mate_shift(input int s, input int p, input int dir);
    int r;
    int t;
    t = int'(mate_thr);
    r = s;
    if (s >= t) begin
      r = s + dir * p;
    end else if (s <= -t) begin
      r = s - dir * p;
    end
    return r[15:0];
  endfunction

  // Applies one item to the shadow table and returns the reply it should produce.
  function automatic table_reply_t run_table_item(input logic [1:0] code,
                                                  input logic [63:0] k,
                                                  input logic [7:0] p,
                                                  input logic [15:0] s,
                                                  input logic [15:0] ev,
                                                  input logic [15:0] mv,
                                                  input logic [7:0] d,
                                                  input logic [1:0] b);
    table_reply_t r;
    int base;
    int e;
    int pick;
    int best;
    int age;
    int prio;
    int din;
    logic found;
    r = '0;
    found = 1'b0;
    base = int'(k & 64'(NUM_SETS - 1)) * WAYS;
    if (code == OP_PROBE) begin
      // First valid way with the full key wins.
      for (int w = 0; w < WAYS; w++) begin
        e = base + w;
        if (!found && table_key[e] == k && table_gen_bound[e][1:0] != BND_NONE) begin
          found = 1'b1;
          r.hit = 1'b1;
          r.score = mate_shift(int'($signed(table_score[e])), int'(p), -1);
          r.eval = table_eval[e];
          r.move = table_move[e];
          r.depth = table_depth[e];
          r.bound = table_gen_bound[e][1:0];
        end
      end
    end else if (code == OP_STORE) begin
      // Empty or same-key way first; otherwise the lowest depth minus twice the age.
      pick = base;
      best = 32'h7FFF_FFFF;
      for (int w = 0; w < WAYS; w++) begin
        e = base + w;
        if (!found) begin
          if (table_gen_bound[e][1:0] == BND_NONE || table_key[e] == k) begin
            pick = e;
            found = 1'b1;
          end else begin
            age = int'((search_gen - (table_gen_bound[e] & GEN_MASK)) & AGE_MASK);
            prio = int'($signed(table_depth[e])) - 2 * age;
            if (prio < best) begin
              best = prio;
              pick = e;
            end
          end
        end
      end
      din = int'($signed(d));
      // An upper bound never replaces a same-key entry of this search that is more than 2 deeper.
      if (!(b == BND_UPPER && table_key[pick] == k &&
            int'($signed(table_depth[pick])) > din + 2 &&
            (table_gen_bound[pick] & GEN_MASK) == search_gen)) begin
        if (din < int'(DEPTH_MIN)) begin
          din = int'(DEPTH_MIN);
        end else if (din > int'(DEPTH_MAX)) begin
          din = int'(DEPTH_MAX);
        end
        table_key[pick] = k;
        table_score[pick] = mate_shift(int'($signed(s)), int'(p), 1);
        table_eval[pick] = ev;
        table_move[pick] = mv;
        table_depth[pick] = din[7:0];
        table_gen_bound[pick] = search_gen | 8'(b);
      end
    end else if (code == OP_NEW_GEN) begin
      search_gen = (search_gen + GEN_STEP) & GEN_MASK;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Retire result beats against the oldest prediction, then predict accepted items.
  always @(posedge clk) begin
    table_reply_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        table_key[i] = '0;
        table_score[i] = '0;
        table_eval[i] = '0;
        table_move[i] = '0;
        table_depth[i] = '0;
        table_gen_bound[i] = '0;
      end
      search_gen = '0;
      mate_thr = MATE_THRESHOLD_RESET;
      expected_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("result beat arrived with no reply pending");
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("hit", 16'(want.hit), 16'(hit));
          check_field("score_out", want.score, score_out);
          check_field("eval_out", want.eval, eval_out);
          check_field("move_word_out", want.move, move_word_out);
          check_field("depth_out", 16'(want.depth), 16'(depth_out));
          check_field("bound_out", 16'(want.bound), 16'(bound_out));
        end
      end
      if (cfg_valid && cfg_ready) begin
        mate_thr = cfg_data;
      end
      if (in_valid && in_ready) begin
        expected_replies.push_back(run_table_item(op, key, ply, score_in, eval_in,
                                                  move_word_in, depth_in, bound_in));
      end
    end
    replies_owed = expected_replies.size();
  end

endmodule

### tb/sv/tb_set_assoc_search_table_unit.sv
// Testbench top for the search table: drives items, threshold writes and result stalls.
module tb_set_assoc_search_table_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sast_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] BND_LOWER = 2'd2;
  localparam logic [1:0] BND_EXACT = 2'd3;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 325;
  localparam int POOL_KEYS       = 32;
  localparam int HOT_SETS        = 5;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [14:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         op = OP_PROBE;
  logic [63:0]        key = '0;
  logic [7:0]         ply = '0;
  logic signed [15:0] score_in = '0;
  logic signed [15:0] eval_in = '0;
  logic [15:0]        move_word_in = '0;
  logic signed [7:0]  depth_in = '0;
  logic [1:0]         bound_in = BND_NONE;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic               hit;
  logic signed [15:0] score_out;
  logic signed [15:0] eval_out;
  logic [15:0]        move_word_out;
  logic signed [7:0]  depth_out;
  logic [1:0]         bound_out;
  int                 mismatch_count;
  int                 replies_owed;

  logic        in_took = 1'b0;
  logic        cfg_took = 1'b0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic [14:0] thr_now = MATE_THRESHOLD_RESET;
  logic [63:0] key_pool [POOL_KEYS];
  logic [9:0]  hot_set [HOT_SETS];

  set_assoc_search_table_unit u_dut (.*);

  search_table_checker u_checker (.*);

  always #5 clk = ~clk;

  // Beat flags, read by the drivers at the following falling edge.
  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    cfg_took <= cfg_valid && cfg_ready;
  end

  // Result-side backpressure.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  // Presents one item after an optional idle gap and holds it until its beat.
  task automatic send_item(input logic [1:0] c, input logic [63:0] k, input logic [7:0] p,
                           input logic [15:0] s, input logic [15:0] ev,
                           input logic [15:0] mv, input logic [7:0] d,
                           input logic [1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    op = c;
    key = k;
    ply = p;
    score_in = s;
    eval_in = ev;
    move_word_in = mv;
    depth_in = d;
    bound_in = b;
    do @(negedge clk); while (!in_took);
  endtask

  task automatic write_threshold(input logic [14:0] v);
    thr_now = v;
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(negedge clk); while (!cfg_took);
    cfg_valid = 1'b0;
  endtask

  // Holds off new items until every predicted reply has come back.
  task automatic drain_replies();
    in_valid = 1'b0;
    while (replies_owed != 0) @(negedge clk);
  endtask

  // Keys clustered on a few sets so that ways fill up and get evicted.
  task automatic refill_key_pool();
    for (int i = 0; i < HOT_SETS; i++) begin
      hot_set[i] = 10'($urandom);
    end
    for (int i = 0; i < POOL_KEYS; i++) begin
      key_pool[i] = {$urandom, 22'($urandom), hot_set[$urandom_range(HOT_SETS - 1)]};
    end
  endtask

  task automatic send_random_item();
    logic [1:0]  c;
    logic [63:0] k;
    logic [15:0] s;
    logic [15:0] mv;
    logic [7:0]  d;
    logic [7:0]  p;
    int          r;
    r = $urandom_range(99);
    if (r < 44) begin
      c = OP_PROBE;
    end else if (r < 90) begin
      c = OP_STORE;
    end else if (r < 96) begin
      c = OP_NEW_GEN;
    end else begin
      c = OP_UNUSED;
    end
    k = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                 : key_pool[$urandom_range(POOL_KEYS - 1)];
    // Scores are random, near plus or minus the mate threshold, near zero, or at the extremes.
    case ($urandom_range(3))
      0: s = 16'($urandom);
      1: begin
        s = 16'(thr_now) + 16'($urandom_range(6)) - 16'd3;
        if ($urandom_range(1) == 1) begin
          s = -s;
        end
      end
      2: s = 16'($urandom_range(1000)) - 16'd500;
      default: s = ($urandom_range(1) == 1) ? 16'h7FFF : 16'h8000;
    endcase
    d = ($urandom_range(1) == 1) ? 8'($urandom) : 8'($urandom_range(33)) - 8'd3;
    p = ($urandom_range(1) == 1) ? 8'($urandom) : 8'($urandom_range(7));
    mv = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
    send_item(c, k, p, s, 16'($urandom), mv, d, 2'($urandom));
  endtask

  task automatic run_directed();
    logic [63:0] ka;
    logic [63:0] kb;
    logic [63:0] kc;
    logic [63:0] kd;
    logic [63:0] ke;
    logic [63:0] kf;
    ka = (64'd1 << 10) | 64'd5;
    kb = (64'd2 << 10) | 64'd5;
    kc = (64'd3 << 10) | 64'd5;
    kd = (64'd4 << 10) | 64'd5;
    ke = (64'd5 << 10) | 64'd5;
    kf = (64'd6 << 10) | 64'd7;
    // Empty table: a probe misses.
    send_item(OP_PROBE, '0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 8'h00, BND_NONE);
    // Extreme fields: the stored score wraps past 16 bits and depth is clamped up.
    send_item(OP_STORE, '1, 8'd255, 16'h7FFF, 16'h8000, 16'hFFFF, 8'h80, BND_EXACT);
    send_item(OP_PROBE, '1, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h7F, BND_EXACT);
    // A bound-none store takes a way but leaves it empty.
    send_item(OP_STORE, '0, 8'd255, 16'h8000, 16'h7FFF, 16'h0001, 8'h7F, BND_NONE);
    // The upper-bound guard also applies to that empty way, since its key matches.
    send_item(OP_STORE, '0, 8'd0, 16'h0005, 16'h0005, 16'h0005, 8'h80, BND_UPPER);
    send_item(OP_PROBE, '0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 8'h00, BND_NONE);
    send_item(OP_STORE, '0, 8'd3, 16'h0010, 16'h0020, 16'h0000, 8'h00, BND_LOWER);
    send_item(OP_PROBE, '0, 8'd3, 16'h0000, 16'h0000, 16'h0000, 8'h00, BND_NONE);
    // Upper bound close in depth replaces; far shallower is dropped.
    send_item(OP_STORE, ka, 8'd1, 16'd100, 16'd7, 16'h1234, 8'd10, BND_EXACT);
    send_item(OP_STORE, ka, 8'd1, 16'd200, 16'd8, 16'h2345, 8'd8, BND_UPPER);
    send_item(OP_PROBE, ka, 8'd1, 16'd0, 16'd0, 16'd0, 8'd0, BND_NONE);
    send_item(OP_STORE, ka, 8'd1, 16'd300, 16'd9, 16'h3456, 8'd20, BND_EXACT);
    send_item(OP_STORE, ka, 8'd1, 16'd400, 16'd10, 16'h4567, 8'd0, BND_UPPER);
    send_item(OP_PROBE, ka, 8'd1, 16'd0, 16'd0, 16'd0, 8'd0, BND_NONE);
    // Fill the set, age it by one search, then evict the lowest priority way.
    send_item(OP_STORE, kb, 8'd0, 16'd1, 16'd1, 16'd1, 8'd30, BND_LOWER);
    send_item(OP_STORE, kc, 8'd0, 16'd2, 16'd2, 16'd2, 8'hFB, BND_LOWER);
    send_item(OP_STORE, kd, 8'd0, 16'd3, 16'd3, 16'd3, 8'd50, BND_LOWER);
    send_item(OP_NEW_GEN, '0, 8'd0, 16'd0, 16'd0, 16'd0, 8'd0, BND_NONE);
    send_item(OP_STORE, ke, 8'd0, 16'd4, 16'd4, 16'd4, 8'd0, BND_EXACT);
    send_item(OP_PROBE, kc, 8'd0, 16'd0, 16'd0, 16'd0, 8'd0, BND_NONE);
    send_item(OP_PROBE, ke, 8'd0, 16'd0, 16'd0, 16'd0, 8'd0, BND_NONE);
    // The unused op code changes nothing.
    send_item(OP_UNUSED, ke, 8'hA5, 16'h5A5A, 16'hA5A5, 16'hFFFF, 8'h80, BND_EXACT);
    // A score exactly at minus the threshold counts as mate.
    send_item(OP_STORE, kf, 8'd7, -16'sd32000, 16'd0, 16'd9, 8'd5, BND_EXACT);
    send_item(OP_PROBE, kf, 8'd3, 16'd0, 16'd0, 16'd0, 8'd0, BND_NONE);
  endtask

  // Stimulus: reset, directed items, then random phases with different idling.
  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;
    write_threshold(MATE_THRESHOLD_RESET);
    run_directed();
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_replies();
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 76;
          stall_pct = 0;
          write_threshold(15'd0);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 76;
          write_threshold(15'h7FFF);
        end
        3: begin
          send_idle_pct = 10;
          stall_pct = 10;
          write_threshold(15'd1);
        end
        4: begin
          send_idle_pct = 0;
          stall_pct = 0;
          write_threshold(15'($urandom_range(32767, 1)));
        end
        default: begin
          send_idle_pct = 76;
          stall_pct = 76;
          write_threshold(MATE_THRESHOLD_RESET);
        end
      endcase
      refill_key_pool();
      repeat (ITEMS_PER_PHASE) send_random_item();
    end
    stall_pct = 0;
    drain_replies();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && replies_owed == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### set_assoc_search_table_unit.f
+incdir+src
src/sast_pkg.sv
src/sast_row_ram.sv
src/sast_way_sel.sv
src/set_assoc_search_table_unit.sv
tb/sv/search_table_checker.sv
tb/sv/tb_set_assoc_search_table_unit.sv
